### hw/rtl/afs_pkg.sv
// Shared types and constants for the animation frame sequencer.
// Used by afs_ctrl, afs_dp and animation_frame_sequencer; depends on nothing.
`timescale 1ns / 1ps

package afs_pkg;

   // Field widths.
   localparam int unsigned OP_W     = 3;
   localparam int unsigned TIME_W   = 24;
   localparam int unsigned INDEX_W  = 16;
   localparam int unsigned FRAME_W  = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned REPEAT_W = 16;
   localparam int unsigned COUNT_W  = 9;
   localparam int unsigned ACC_W    = 40;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   // The frame field is eight bits, so no more than this many frames exist.
   localparam int unsigned FRAME_LIMIT = 256;

   // Step counter width of the remainder unit: one step per index bit.
   localparam int unsigned MOD_CNT_W = 4;

   // Command codes.
   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_PLAY    = 3'd1;
   localparam logic [OP_W-1:0] OP_PAUSE   = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
   localparam logic [OP_W-1:0] OP_SETF    = 3'd4;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd5;

   // Playback status codes.
   localparam logic [STATUS_W-1:0] ST_PLAY  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PAUSE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STOP  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATUS = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the incoming word, clear the remainder unit
      logic acc_add;   // add tick time into the accumulator (saturating)
      logic mod_step;  // one restoring step of index modulo frame count
      logic commit;    // apply the command to the state, present the result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_tick;
      logic op_setf;
      logic mod_last;
      logic out_free;
   } sts_type;

endpackage

### hw/rtl/afs_ctrl.sv
// Controller state machine of the animation frame sequencer.
// Depends on afs_pkg; drives the command struct of afs_dp.
`timescale 1ns / 1ps

module afs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  afs_pkg::sts_type sts,
   output afs_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_MOD  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            priority if (sts.op_tick) begin
               cmd.acc_add = 1'b1;
               state_in    = S_DONE;
            end else if (sts.op_setf) begin
               state_in = S_MOD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Wait here until the result register has room.
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/afs_dp.sv
// Datapath of the animation frame sequencer: playback state, accumulator,
// remainder unit and result register. Depends on afs_pkg; driven by afs_ctrl.
`timescale 1ns / 1ps

module afs_dp #(
   parameter int MAX_FRAMES = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [afs_pkg::OP_W-1:0]               req_op,
   input  logic [afs_pkg::TIME_W-1:0]             req_tick_time,
   input  logic [afs_pkg::INDEX_W-1:0]            req_frame_index,
   input  logic [afs_pkg::TIME_W-1:0]             cfg_frame_period,
   input  logic                                   cfg_loop_enable,
   input  logic [afs_pkg::REPEAT_W-1:0]           cfg_repeat_count,
   input  logic [afs_pkg::COUNT_W-1:0]            cfg_frame_count,
   input  logic [afs_pkg::STATUS_W-1:0]           cfg_start_status,
   input  afs_pkg::cmd_type                       cmd,
   output afs_pkg::sts_type                       sts,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [afs_pkg::FRAME_W-1:0]            rsp_frame,
   output logic [afs_pkg::STATUS_W-1:0]           rsp_status,
   output logic                                   rsp_finished
);

   localparam int unsigned CAP =
      (MAX_FRAMES < afs_pkg::FRAME_LIMIT) ? MAX_FRAMES : afs_pkg::FRAME_LIMIT;
   localparam logic [afs_pkg::COUNT_W-1:0] CAP_N = afs_pkg::COUNT_W'(CAP);

   // Latched command word.
   logic [afs_pkg::OP_W-1:0]      op_ff;
   logic [afs_pkg::TIME_W-1:0]    tick_ff;
   logic [afs_pkg::INDEX_W-1:0]   idx_ff,   idx_in;

   // Playback state.
   logic [afs_pkg::ACC_W-1:0]     acc_ff,   acc_in;
   logic [afs_pkg::FRAME_W-1:0]   frame_ff, frame_in;
   logic [afs_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [afs_pkg::REPEAT_W-1:0]  rep_ff,   rep_in;

   // Remainder unit.
   logic [afs_pkg::FRAME_W-1:0]   rem_ff,   rem_in;
   logic [afs_pkg::MOD_CNT_W-1:0] cnt_ff,   cnt_in;

   // Result register.
   logic                          fin_ff,   fin_in;
   logic                          valid_ff, valid_in;

   logic [afs_pkg::COUNT_W-1:0]   count_n;
   logic [afs_pkg::COUNT_W-1:0]   shifted;
   logic [afs_pkg::COUNT_W-1:0]   frame_inc;
   logic [afs_pkg::ACC_W:0]       acc_sum;
   logic [afs_pkg::ACC_W-1:0]     period_x;
   logic [afs_pkg::REPEAT_W-1:0]  rep_dec;

   // Effective frame count: zero counts as one, clamped to CAP.
   always_comb begin
      priority if (cfg_frame_count == '0) begin
         count_n = afs_pkg::COUNT_W'(1);
      end else if (cfg_frame_count > CAP_N) begin
         count_n = CAP_N;
      end else begin
         count_n = cfg_frame_count;
      end
   end

   assign shifted   = {rem_ff, idx_ff[afs_pkg::INDEX_W-1]};
   assign frame_inc = {1'b0, frame_ff} + afs_pkg::COUNT_W'(1);
   assign acc_sum   = {1'b0, acc_ff} + {{(afs_pkg::ACC_W + 1 - afs_pkg::TIME_W){1'b0}}, tick_ff};
   assign period_x  = {{(afs_pkg::ACC_W - afs_pkg::TIME_W){1'b0}}, cfg_frame_period};
   assign rep_dec   = (rep_ff != '0) ? (rep_ff - afs_pkg::REPEAT_W'(1)) : rep_ff;

   assign sts.op_tick  = (op_ff == afs_pkg::OP_TICK);
   assign sts.op_setf  = (op_ff == afs_pkg::OP_SETF);
   assign sts.mod_last = (cnt_ff == '1);
   assign sts.out_free = !valid_ff || rsp_ready;

   always_comb begin
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      frame_in  = frame_ff;
      status_in = status_ff;
      rep_in    = rep_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      valid_in  = valid_ff && !rsp_ready;

      if (cmd.capture) begin
         idx_in = req_frame_index;
         rem_in = '0;
         cnt_in = '0;
      end

      if (cmd.mod_step) begin
         // Remainder stays below the count, so it fits the frame field.
         if (shifted >= count_n) begin
            rem_in = shifted[afs_pkg::FRAME_W-1:0] - count_n[afs_pkg::FRAME_W-1:0];
         end else begin
            rem_in = shifted[afs_pkg::FRAME_W-1:0];
         end
         idx_in = {idx_ff[afs_pkg::INDEX_W-2:0], 1'b0};
         cnt_in = cnt_ff + afs_pkg::MOD_CNT_W'(1);
      end

      if (cmd.acc_add && (status_ff == afs_pkg::ST_PLAY)) begin
         acc_in = acc_sum[afs_pkg::ACC_W] ? '1 : acc_sum[afs_pkg::ACC_W-1:0];
      end

      if (cmd.commit) begin
         valid_in = 1'b1;
         fin_in   = 1'b0;
         unique case (op_ff)
            afs_pkg::OP_TICK: begin
               if ((status_ff == afs_pkg::ST_PLAY) && (acc_ff > period_x)) begin
                  acc_in = acc_ff - period_x;
                  if (frame_inc < count_n) begin
                     frame_in = frame_inc[afs_pkg::FRAME_W-1:0];
                  end else begin
                     frame_in = '0;
                     if (!cfg_loop_enable) begin
                        rep_in = rep_dec;
                        if (rep_dec == '0) begin
                           status_in = afs_pkg::ST_STOP;
                           fin_in    = 1'b1;
                        end
                     end
                  end
               end
            end
            afs_pkg::OP_PLAY:  status_in = afs_pkg::ST_PLAY;
            afs_pkg::OP_PAUSE: status_in = afs_pkg::ST_PAUSE;
            afs_pkg::OP_STOP: begin
               status_in = afs_pkg::ST_STOP;
               frame_in  = '0;
               acc_in    = '0;
            end
            afs_pkg::OP_SETF: begin
               frame_in = rem_ff;
               acc_in   = '0;
            end
            afs_pkg::OP_RESTART: begin
               frame_in  = '0;
               acc_in    = '0;
               rep_in    = cfg_repeat_count;
               status_in = (cfg_start_status > afs_pkg::ST_STOP) ?
                           afs_pkg::ST_STOP : cfg_start_status;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         tick_ff <= req_tick_time;
      end
      idx_ff <= idx_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         frame_ff  <= '0;
         status_ff <= afs_pkg::ST_STOP;
         rep_ff    <= '0;
         fin_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         frame_ff  <= frame_in;
         status_ff <= status_in;
         rep_ff    <= rep_in;
         fin_ff    <= fin_in;
         valid_ff  <= valid_in;
      end
   end

   // Frame and status change only on a commit, which never happens while an
   // untaken result is pending, so they serve directly as result fields.
   assign rsp_valid    = valid_ff;
   assign rsp_frame    = frame_ff;
   assign rsp_status   = status_ff;
   assign rsp_finished = fin_ff;

endmodule

### hw/rtl/animation_frame_sequencer.sv
// Top level of the animation frame sequencer: configuration registers,
// controller and datapath. Depends on afs_pkg, afs_ctrl and afs_dp.
`timescale 1ns / 1ps

// The sequencer takes one command word at a time (tick, play, pause, stop,
// set frame, restart) and returns one result word per command carrying the
// current frame, the playback status and a finished flag. Every word is
// latched on accept and then passes an execute state, in which a tick adds
// its time into the saturating 40-bit accumulator while playing, and a done
// state, in which the period compare, frame advance and repeat count update
// are committed. For set frame, the index is reduced modulo the frame count
// before the done state, by a restoring remainder unit that handles
// one of the sixteen index bits per cycle. A new word is accepted as soon as
// the previous one has been committed, even if its result word is still
// waiting to be taken; the new word then holds before its commit until the
// result register is free. Configuration registers are written through the
// csr port and should only change while no command is in flight. The
// MAX_FRAMES parameter caps the effective frame count together with the
// eight-bit frame field.
module animation_frame_sequencer #(
   parameter int MAX_FRAMES = 256
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [afs_pkg::OP_W-1:0]            req_op,
   input  logic [afs_pkg::TIME_W-1:0]          req_tick_time,
   input  logic [afs_pkg::INDEX_W-1:0]         req_frame_index,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [afs_pkg::FRAME_W-1:0]         rsp_frame,
   output logic [afs_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_finished,

   input  logic                                csr_write_en,
   input  logic [afs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [afs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers, with their reset values.
   logic [afs_pkg::TIME_W-1:0]   frame_period_ff;
   logic                         loop_enable_ff;
   logic [afs_pkg::REPEAT_W-1:0] repeat_count_ff;
   logic [afs_pkg::COUNT_W-1:0]  frame_count_ff;
   logic [afs_pkg::STATUS_W-1:0] start_status_ff;

   afs_pkg::cmd_type cmd;
   afs_pkg::sts_type sts;

   // Each write takes the low bits of the data word that the register needs.
   // Indexes past the last register are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_period_ff <= afs_pkg::TIME_W'(100000);
         loop_enable_ff  <= 1'b1;
         repeat_count_ff <= afs_pkg::REPEAT_W'(1);
         frame_count_ff  <= afs_pkg::COUNT_W'(1);
         start_status_ff <= afs_pkg::ST_STOP;
      end else if (csr_write_en) begin
         unique case (csr_index)
            afs_pkg::CSR_FRAME_PERIOD: frame_period_ff <= csr_wdata;
            afs_pkg::CSR_LOOP_ENABLE:  loop_enable_ff  <= csr_wdata[0];
            afs_pkg::CSR_REPEAT_COUNT:
               repeat_count_ff <= csr_wdata[afs_pkg::REPEAT_W-1:0];
            afs_pkg::CSR_FRAME_COUNT:
               frame_count_ff <= csr_wdata[afs_pkg::COUNT_W-1:0];
            afs_pkg::CSR_START_STATUS:
               start_status_ff <= csr_wdata[afs_pkg::STATUS_W-1:0];
            default: ;
         endcase
      end
   end

   // The controller sequences each word; the datapath holds the playback state.
   afs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   afs_dp #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_tick_time    (req_tick_time),
      .req_frame_index  (req_frame_index),
      .cfg_frame_period (frame_period_ff),
      .cfg_loop_enable  (loop_enable_ff),
      .cfg_repeat_count (repeat_count_ff),
      .cfg_frame_count  (frame_count_ff),
      .cfg_start_status (start_status_ff),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame        (rsp_frame),
      .rsp_status       (rsp_status),
      .rsp_finished     (rsp_finished)
   );

   // A finished flag always comes with the stopped status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_status == afs_pkg::ST_STOP)
      else $error("finished reported without stopped status");

   // The sequencer works on one word at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while one is in flight");

   // The status never takes the unused code: stopped is the highest one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_status <= afs_pkg::ST_STOP)
      else $error("status holds an unused code");

endmodule
